// File: sv/cdxa_pkg.sv
// ----------------------------------------------------------------------------
// CD-XA sector demux package
// Shared types, status codes and constants for the sector demux block.
// ----------------------------------------------------------------------------
package cdxa_pkg;

    // Default number of channels that can carry registered streams.
    localparam int CHANNELS_DEF = 32;

    // Sector and video chunk constants.
    localparam logic [10:0] CHUNK_BYTES    = 11'h7E0;
    localparam logic [7:0]  TYPE_MASK      = 8'h0E;
    localparam logic [7:0]  TYPE_DATA      = 8'h08;
    localparam logic [7:0]  TYPE_AUDIO     = 8'h04;
    localparam logic [7:0]  TYPE_VIDEO     = 8'h02;
    localparam logic [31:0] VIDEO_MAGIC    = 32'h8001_0160;
    localparam logic [11:0] SECTOR_PAYLOAD = 12'd2304;
    localparam logic [15:0] RATE_HALF      = 16'd18900;
    localparam logic [15:0] RATE_FULL      = 16'd37800;
    localparam logic [3:0]  BITS_EIGHT     = 4'd8;
    localparam logic [3:0]  BITS_FOUR      = 4'd4;

    // Operation codes.
    typedef enum logic {
        OP_SCAN  = 1'b0,
        OP_DEMUX = 1'b1
    } t_op;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_IGNORED    = 3'd0,
        ST_VIDEO_CHNK = 3'd1,
        ST_AUDIO_SECT = 3'd2,
        ST_VIDEO_REG  = 3'd3,
        ST_AUDIO_REG  = 3'd4,
        ST_BAD_CHAN   = 3'd5
    } t_status;

    // One decoded sector header.
    typedef struct packed {
        logic        operation;
        logic [7:0]  channel;
        logic [7:0]  submode;
        logic [7:0]  coding_info;
        logic [31:0] magic_word;
        logic [15:0] chunk_index;
        logic [15:0] chunk_count;
        logic [31:0] frame_bytes;
        logic [15:0] width_in;
        logic [15:0] height_in;
    } t_sector_in;

    // One result word.
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  stream_number;
        logic        frame_start;
        logic [26:0] dest_offset;
        logic [11:0] copy_length;
        logic        frame_done;
        logic [31:0] frame_stamp;
        logic [15:0] sample_rate;
        logic        stereo;
        logic [3:0]  sample_bits;
        logic [15:0] width_out;
        logic [15:0] height_out;
    } t_sector_out;

    // State changes requested by one sector.
    typedef struct packed {
        logic set_video;
        logic set_audio;
        logic open_frame;
        logic close_frame;
        logic bump_stamp;
    } t_state_upd;

endpackage

// File: sv/cdxa_if.sv
// ----------------------------------------------------------------------------
// CD-XA sector demux channels
// Valid/ready channels for sector headers and result words.
// ----------------------------------------------------------------------------

// Sector header channel.
interface cdxa_sector_if;
    logic                  valid;
    logic                  ready;
    cdxa_pkg::t_sector_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel.
interface cdxa_result_if;
    logic                  valid;
    logic                  ready;
    cdxa_pkg::t_sector_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/cdxa_chan_state.sv
// ----------------------------------------------------------------------------
// CD-XA channel state
// Per-channel registration and open-frame bits plus the frame stamp counter.
// ----------------------------------------------------------------------------
module cdxa_chan_state #(
    parameter int CHANNELS = cdxa_pkg::CHANNELS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_commit,
    input  cdxa_pkg::t_state_upd    i_upd,
    input  logic [CHANNELS-1:0]     i_mask,
    output logic [CHANNELS-1:0]     o_video_reg,
    output logic [CHANNELS-1:0]     o_audio_reg,
    output logic [CHANNELS-1:0]     o_frame_open,
    output logic [31:0]             o_stamp
);

    logic [CHANNELS-1:0] r_video_reg, n_video_reg;
    logic [CHANNELS-1:0] r_audio_reg, n_audio_reg;
    logic [CHANNELS-1:0] r_frame_open, n_frame_open;
    logic [31:0]         r_stamp, n_stamp;

    // Next state: a frame that opens and closes on one chunk ends closed.
    always_comb begin
        n_video_reg  = r_video_reg  | (i_upd.set_video  ? i_mask : '0);
        n_audio_reg  = r_audio_reg  | (i_upd.set_audio  ? i_mask : '0);
        n_frame_open = (r_frame_open | (i_upd.open_frame ? i_mask : '0))
                       & ~(i_upd.close_frame ? i_mask : '0);
        n_stamp      = i_upd.bump_stamp ? r_stamp + 32'd1 : r_stamp;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_reg  <= '0;
            r_audio_reg  <= '0;
            r_frame_open <= '0;
            r_stamp      <= '0;
        end else if (i_commit) begin
            r_video_reg  <= n_video_reg;
            r_audio_reg  <= n_audio_reg;
            r_frame_open <= n_frame_open;
            r_stamp      <= n_stamp;
        end
    end

    assign o_video_reg  = r_video_reg;
    assign o_audio_reg  = r_audio_reg;
    assign o_frame_open = r_frame_open;
    assign o_stamp      = r_stamp;

endmodule

// File: sv/cdxa_sector_eval.sv
// ----------------------------------------------------------------------------
// CD-XA sector evaluation
// Classifies one sector header against the channel state and forms the
// result word and the state changes it causes.
// ----------------------------------------------------------------------------
module cdxa_sector_eval #(
    parameter int CHANNELS = cdxa_pkg::CHANNELS_DEF
) (
    input  cdxa_pkg::t_sector_in    i_item,
    input  logic [CHANNELS-1:0]     i_video_reg,
    input  logic [CHANNELS-1:0]     i_audio_reg,
    input  logic [CHANNELS-1:0]     i_frame_open,
    input  logic [31:0]             i_stamp,
    output cdxa_pkg::t_sector_out   o_res,
    output cdxa_pkg::t_state_upd    o_upd,
    output logic [CHANNELS-1:0]     o_mask
);

    localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [7:0]          w_type;
    logic                w_is_video;
    logic                w_is_audio;
    logic                w_ch_ok;
    logic [CHANNELS-1:0] w_one;
    logic [CHANNELS-1:0] w_mask;
    logic                w_v_hit;
    logic                w_a_hit;
    logic                w_f_open;
    logic [26:0]         w_off;
    logic [31:0]         w_off_ext;
    logic [31:0]         w_rem;
    logic [11:0]         w_len;
    logic                w_last;

    // Sector type and channel decode.
    always_comb begin
        w_type     = i_item.submode & cdxa_pkg::TYPE_MASK;
        w_is_video = (w_type == cdxa_pkg::TYPE_DATA) || (w_type == cdxa_pkg::TYPE_VIDEO);
        w_is_audio = (w_type == cdxa_pkg::TYPE_AUDIO);
        w_ch_ok    = {1'b0, i_item.channel} < 9'(CHANNELS);
        w_one      = '0;
        w_one[0]   = 1'b1;
        w_mask     = w_ch_ok ? (w_one << i_item.channel[ChIdxW-1:0]) : '0;
        w_v_hit    = |(i_video_reg & w_mask);
        w_a_hit    = |(i_audio_reg & w_mask);
        w_f_open   = |(i_frame_open & w_mask);
    end

    // Video chunk placement: offset, clamped copy length and last-chunk test.
    always_comb begin
        w_off     = {11'd0, i_item.chunk_index} * {16'd0, cdxa_pkg::CHUNK_BYTES};
        w_off_ext = {5'd0, w_off};
        w_rem     = i_item.frame_bytes - w_off_ext;
        if (i_item.frame_bytes > w_off_ext) begin
            if (w_rem > {21'd0, cdxa_pkg::CHUNK_BYTES}) begin
                w_len = {1'b0, cdxa_pkg::CHUNK_BYTES};
            end else begin
                w_len = w_rem[11:0];
            end
        end else begin
            w_len = '0;
        end
        w_last = (i_item.chunk_count != 16'd0)
                 && (i_item.chunk_index == i_item.chunk_count - 16'd1);
    end

    // Result word and state changes.
    always_comb begin
        o_res = '0;
        o_upd = '0;
        if (!w_ch_ok) begin
            if (i_item.operation == cdxa_pkg::OP_SCAN) begin
                o_res.status = cdxa_pkg::ST_BAD_CHAN;
            end
        end else if (i_item.operation == cdxa_pkg::OP_SCAN) begin
            if (w_is_video && (i_item.magic_word == cdxa_pkg::VIDEO_MAGIC) && !w_v_hit) begin
                o_upd.set_video     = 1'b1;
                o_res.status        = cdxa_pkg::ST_VIDEO_REG;
                o_res.stream_number = i_item.channel[5:0] + 6'd32;
                o_res.width_out     = i_item.width_in;
                o_res.height_out    = i_item.height_in;
            end else if (w_is_audio && !w_a_hit) begin
                o_upd.set_audio     = 1'b1;
                o_res.status        = cdxa_pkg::ST_AUDIO_REG;
                o_res.stream_number = i_item.channel[5:0];
                o_res.sample_rate   = i_item.coding_info[2] ? cdxa_pkg::RATE_HALF
                                                            : cdxa_pkg::RATE_FULL;
                o_res.stereo        = i_item.coding_info[0];
                o_res.sample_bits   = i_item.coding_info[4] ? cdxa_pkg::BITS_EIGHT
                                                            : cdxa_pkg::BITS_FOUR;
            end
        end else begin
            if (w_is_video && w_v_hit) begin
                o_res.status        = cdxa_pkg::ST_VIDEO_CHNK;
                o_res.stream_number = i_item.channel[5:0] + 6'd32;
                o_res.frame_start   = !w_f_open;
                o_upd.open_frame    = !w_f_open;
                o_res.dest_offset   = w_off;
                o_res.copy_length   = w_len;
                if (w_last) begin
                    o_res.frame_done  = 1'b1;
                    o_res.frame_stamp = i_stamp;
                    o_upd.bump_stamp  = 1'b1;
                    o_upd.close_frame = 1'b1;
                end
            end else if (w_is_audio && w_a_hit) begin
                o_res.status        = cdxa_pkg::ST_AUDIO_SECT;
                o_res.stream_number = i_item.channel[5:0];
                o_res.copy_length   = cdxa_pkg::SECTOR_PAYLOAD;
            end
        end
    end

    assign o_mask = w_mask;

endmodule

// File: sv/cdxa_str_sector_demux.sv
// ----------------------------------------------------------------------------
// CD-XA sector stream demux
// Registers audio and video streams per channel and routes sector headers
// to them, placing video chunks inside their frame buffers.
// ----------------------------------------------------------------------------
// The block takes one sector header word per cycle, stalls aside, and
// returns one result word per header: a header is captured in the input
// register, evaluated against the per-channel state in one pass, and the
// result lands in the output register while the state updates at the same
// edge, so the next header sees it. The only stall comes from the result
// side: while a result waits and the sink is not ready, one more header is
// held in the input register before ready drops.
module cdxa_str_sector_demux #(
    parameter int CHANNELS = cdxa_pkg::CHANNELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cdxa_sector_if.sink   i_sec,
    cdxa_result_if.source o_res
);

    logic                  r_in_valid;
    cdxa_pkg::t_sector_in  r_in;
    logic                  r_out_valid;
    cdxa_pkg::t_sector_out r_out;

    logic                  w_adv;
    logic                  w_commit;
    cdxa_pkg::t_sector_out w_res;
    cdxa_pkg::t_state_upd  w_upd;
    logic [CHANNELS-1:0]   w_mask;
    logic [CHANNELS-1:0]   w_video_reg;
    logic [CHANNELS-1:0]   w_audio_reg;
    logic [CHANNELS-1:0]   w_frame_open;
    logic [31:0]           w_stamp;

    // Pipeline advance: the result register is free or being drained.
    assign w_adv       = !r_out_valid || o_res.ready;
    assign w_commit    = r_in_valid && w_adv;
    assign i_sec.ready = !r_in_valid || w_adv;

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_sec.ready) begin
                r_in_valid <= i_sec.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_sec.valid && i_sec.ready) begin
            r_in <= i_sec.data;
        end
        if (w_commit) begin
            r_out <= w_res;
        end
    end

    // Per-channel state.
    cdxa_chan_state #(
        .CHANNELS (CHANNELS)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_commit     (w_commit),
        .i_upd        (w_upd),
        .i_mask       (w_mask),
        .o_video_reg  (w_video_reg),
        .o_audio_reg  (w_audio_reg),
        .o_frame_open (w_frame_open),
        .o_stamp      (w_stamp)
    );

    // Header evaluation.
    cdxa_sector_eval #(
        .CHANNELS (CHANNELS)
    ) u_eval (
        .i_item       (r_in),
        .i_video_reg  (w_video_reg),
        .i_audio_reg  (w_audio_reg),
        .i_frame_open (w_frame_open),
        .i_stamp      (w_stamp),
        .o_res        (w_res),
        .o_upd        (w_upd),
        .o_mask       (w_mask)
    );

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // The stamp counter moves by one exactly when a committed chunk ends a frame.
    a_stamp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_upd.bump_stamp) |=> (w_stamp == $past(w_stamp) + 32'd1))
        else $error("frame stamp did not advance on a completed frame");

    // Registration bits only ever get set.
    a_reg_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (((w_video_reg & $past(w_video_reg)) == $past(w_video_reg))
                         && ((w_audio_reg & $past(w_audio_reg)) == $past(w_audio_reg))))
        else $error("a stream registration was lost");

    // A frame stamp appears only on a video chunk that completes a frame.
    a_stamp_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.frame_done) |-> (r_out.frame_stamp == 32'd0))
        else $error("frame stamp given without a completed frame");

    // A video chunk never copies more than one chunk of payload.
    a_chunk_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == cdxa_pkg::ST_VIDEO_CHNK))
        |-> (r_out.copy_length <= {1'b0, cdxa_pkg::CHUNK_BYTES}))
        else $error("video copy length exceeds chunk size");

endmodule

// File: dv/cdxa_demux_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CD-XA sector demux checker
// Watches the header and result channels of the sector demux and keeps its
// own copy of the per-channel stream state. It works out the result word for
// every accepted header, then compares each accepted result word with the
// oldest word still outstanding, field by field.
// ----------------------------------------------------------------------------
module cdxa_demux_checker
    import cdxa_pkg::*;
#(
    parameter int CHANNELS = cdxa_pkg::CHANNELS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cdxa_sector_if i_sec,
    cdxa_result_if i_res,
    input  logic   i_end_check,
    output int     o_mismatches,
    output int     o_pending
);

    // Shadow of the block's stream state.
    logic [31:0] audio_streams;
    logic [31:0] video_streams;
    logic [31:0] open_frames;
    logic [31:0] next_stamp;

    t_sector_out demux_results[$];
    int          mismatch_count = 0;
    int          result_count = 0;
    logic        end_seen = 1'b0;

    assign o_mismatches = mismatch_count;

    // Print one line per problem and count it.
    task automatic report_mismatch(input string what);
        $display("[%0t] checker: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d, %s: got 0x%0h, want 0x%0h",
                                      result_count, field, got, want));
        end
    endtask

    // Work out the result word of one header and update the shadow state.
    task automatic route_sector(input t_sector_in hdr);
        t_sector_out r;
        logic [7:0]  kind;
        logic        is_video;
        logic        is_audio;
        logic [31:0] chan_bit;
        logic [47:0] offset;
        logic [47:0] span;

        r        = '0;
        kind     = hdr.submode & TYPE_MASK;
        is_video = (kind == TYPE_DATA) || (kind == TYPE_VIDEO);
        is_audio = (kind == TYPE_AUDIO);
        chan_bit = 32'd1 << hdr.channel[4:0];

        if (hdr.channel >= CHANNELS) begin
            // Out-of-range channels are flagged on scan and dropped on demux.
            if (hdr.operation == OP_SCAN) begin
                r.status = ST_BAD_CHAN;
            end
        end else if (hdr.operation == OP_SCAN) begin
            if (is_video && hdr.magic_word == VIDEO_MAGIC &&
                !(video_streams & chan_bit)) begin
                video_streams |= chan_bit;
                r.status        = ST_VIDEO_REG;
                r.stream_number = 6'(hdr.channel + 8'd32);
                r.width_out     = hdr.width_in;
                r.height_out    = hdr.height_in;
            end else if (is_audio && !(audio_streams & chan_bit)) begin
                audio_streams |= chan_bit;
                r.status        = ST_AUDIO_REG;
                r.stream_number = hdr.channel[5:0];
                r.sample_rate   = hdr.coding_info[2] ? RATE_HALF : RATE_FULL;
                r.stereo        = hdr.coding_info[0];
                r.sample_bits   = hdr.coding_info[4] ? BITS_EIGHT : BITS_FOUR;
            end
        end else begin
            if (is_video && (video_streams & chan_bit)) begin
                r.status        = ST_VIDEO_CHNK;
                r.stream_number = 6'(hdr.channel + 8'd32);
                if (!(open_frames & chan_bit)) begin
                    r.frame_start = 1'b1;
                    open_frames |= chan_bit;
                end
                // Chunk placement, with the copy clamped to one chunk and
                // dropped entirely past the end of the frame.
                offset      = 48'(hdr.chunk_index) * 48'(CHUNK_BYTES);
                span        = '0;
                if (48'(hdr.frame_bytes) > offset) begin
                    span = 48'(hdr.frame_bytes) - offset;
                    if (span > 48'(CHUNK_BYTES)) begin
                        span = 48'(CHUNK_BYTES);
                    end
                end
                r.dest_offset = offset[26:0];
                r.copy_length = span[11:0];
                if (hdr.chunk_count != 16'd0 &&
                    hdr.chunk_index == hdr.chunk_count - 16'd1) begin
                    r.frame_done  = 1'b1;
                    r.frame_stamp = next_stamp;
                    next_stamp    = next_stamp + 32'd1;
                    open_frames  &= ~chan_bit;
                end
            end else if (is_audio && (audio_streams & chan_bit)) begin
                r.status        = ST_AUDIO_SECT;
                r.stream_number = hdr.channel[5:0];
                r.copy_length   = SECTOR_PAYLOAD;
            end
        end
        demux_results.push_back(r);
    endtask

    // Predict on every accepted header word, compare every accepted result.
    always @(posedge i_clk) begin
        t_sector_out want;
        t_sector_out got;

        if (!i_rst_n) begin
            audio_streams = '0;
            video_streams = '0;
            open_frames   = '0;
            next_stamp    = '0;
            demux_results.delete();
        end else begin
            if (i_sec.valid === 1'b1 && i_sec.ready === 1'b1) begin
                route_sector(i_sec.data);
            end
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                got = i_res.data;
                if (demux_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none outstanding",
                                              result_count));
                end else begin
                    want = demux_results.pop_front();
                    check_field("status", 32'(got.status), 32'(want.status));
                    check_field("stream_number", 32'(got.stream_number),
                                32'(want.stream_number));
                    check_field("frame_start", 32'(got.frame_start),
                                32'(want.frame_start));
                    check_field("dest_offset", 32'(got.dest_offset),
                                32'(want.dest_offset));
                    check_field("copy_length", 32'(got.copy_length),
                                32'(want.copy_length));
                    check_field("frame_done", 32'(got.frame_done), 32'(want.frame_done));
                    check_field("frame_stamp", got.frame_stamp, want.frame_stamp);
                    check_field("sample_rate", 32'(got.sample_rate),
                                32'(want.sample_rate));
                    check_field("stereo", 32'(got.stereo), 32'(want.stereo));
                    check_field("sample_bits", 32'(got.sample_bits),
                                32'(want.sample_bits));
                    check_field("width_out", 32'(got.width_out), 32'(want.width_out));
                    check_field("height_out", 32'(got.height_out), 32'(want.height_out));
                end
                result_count++;
            end
            // Anything still outstanding at the end never came out.
            if (i_end_check && !end_seen) begin
                end_seen = 1'b1;
                if (demux_results.size() != 0) begin
                    report_mismatch($sformatf("%0d result words never arrived",
                                              demux_results.size()));
                end
            end
        end
        o_pending <= demux_results.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CD-XA sector demux testbench
// Drives a directed set of sector headers covering registration, routing and
// chunk placement corner cases, then a long run of random frame sequences,
// audio sectors, scans and noise, with random gaps on both channels. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
    import cdxa_pkg::*;

    localparam int RANDOM_SECTORS = 800;
    localparam int DRAIN_LIMIT    = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        end_check;
    logic [31:0] cycle_count = '0;
    logic        calm;
    int          mismatches;
    int          pending;
    int          stall_left = 0;

    cdxa_sector_if sec_if ();
    cdxa_result_if res_if ();

    cdxa_str_sector_demux i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sec   (sec_if),
        .o_res   (res_if)
    );

    cdxa_demux_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sec        (sec_if),
        .i_res        (res_if),
        .i_end_check  (end_check),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #1 i_clk = ~i_clk;

    // A quarter of the time both sides run without gaps.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 32'd1;
    end
    assign calm = (cycle_count[9:8] == 2'b11);

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Result sink with random back-pressure.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            res_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left <= pick_gap();
            end
        end
    end

    function automatic t_sector_in make_sector(
        input t_op         op,
        input logic [7:0]  chan,
        input logic [7:0]  submode,
        input logic [7:0]  coding,
        input logic [31:0] magic,
        input logic [15:0] idx,
        input logic [15:0] cnt,
        input logic [31:0] fbytes,
        input logic [15:0] w,
        input logic [15:0] h
    );
        t_sector_in s;
        s.operation   = op;
        s.channel     = chan;
        s.submode     = submode;
        s.coding_info = coding;
        s.magic_word  = magic;
        s.chunk_index = idx;
        s.chunk_count = cnt;
        s.frame_bytes = fbytes;
        s.width_in    = w;
        s.height_in   = h;
        return s;
    endfunction

    // Submode with the given type and random bits elsewhere.
    function automatic logic [7:0] with_kind(input logic [7:0] kind);
        return (8'($urandom) & ~TYPE_MASK) | kind;
    endfunction

    function automatic t_sector_in noise_sector();
        return make_sector(t_op'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                           8'($urandom), $urandom, 16'($urandom), 16'($urandom),
                           $urandom, 16'($urandom), 16'($urandom));
    endfunction

    // Present one header word after an optional gap and wait for acceptance.
    task automatic send_sector(input t_sector_in hdr);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap != 0) begin
            sec_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sec_if.valid <= 1'b1;
        sec_if.data  <= hdr;
        @(posedge i_clk);
        while (sec_if.ready !== 1'b1) @(posedge i_clk);
    endtask

    // Stimulus and verdict.
    initial begin
        int          well_formed;
        int          pick;
        int          waited;
        int          last;
        logic [7:0]  chan;
        logic [7:0]  kind;
        logic [15:0] cnt;
        logic [31:0] fbytes;

        sec_if.valid <= 1'b0;
        sec_if.data  <= '0;
        i_rst_n      <= 1'b0;
        end_check    <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bad channels on scan and demux, unregistered and rejected streams.
        send_sector(make_sector(OP_SCAN, 8'd32, TYPE_DATA, 8'h00, VIDEO_MAGIC,
                                16'd0, 16'd1, 32'd100, 16'd1, 16'd1));
        send_sector(make_sector(OP_SCAN, 8'd255, TYPE_AUDIO, 8'hFF, 32'd0,
                                16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd200, TYPE_VIDEO, 8'h00, VIDEO_MAGIC,
                                16'd0, 16'd1, 32'd100, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd0, TYPE_VIDEO, 8'h00, VIDEO_MAGIC,
                                16'd0, 16'd1, 32'd100, 16'd0, 16'd0));
        send_sector(make_sector(OP_SCAN, 8'd0, TYPE_DATA, 8'h00, ~VIDEO_MAGIC,
                                16'd0, 16'd0, 32'd0, 16'd5, 16'd5));
        send_sector(make_sector(OP_SCAN, 8'd0, TYPE_DATA | TYPE_AUDIO, 8'h00, VIDEO_MAGIC,
                                16'd0, 16'd0, 32'd0, 16'd5, 16'd5));

        // Registrations, repeats and both audio formats.
        send_sector(make_sector(OP_SCAN, 8'd0, TYPE_DATA, 8'h00, VIDEO_MAGIC,
                                16'd0, 16'd0, 32'd0, 16'hFFFF, 16'h0000));
        send_sector(make_sector(OP_SCAN, 8'd0, TYPE_VIDEO, 8'h00, VIDEO_MAGIC,
                                16'd0, 16'd0, 32'd0, 16'd1, 16'hFFFF));
        send_sector(make_sector(OP_SCAN, 8'd31, 8'hF0 | TYPE_VIDEO, 8'h00, VIDEO_MAGIC,
                                16'd0, 16'd0, 32'd0, 16'd320, 16'd240));
        send_sector(make_sector(OP_SCAN, 8'd0, TYPE_AUDIO, 8'h15, 32'd0,
                                16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
        send_sector(make_sector(OP_SCAN, 8'd31, TYPE_AUDIO, 8'hEA, 32'd0,
                                16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
        send_sector(make_sector(OP_SCAN, 8'd0, TYPE_AUDIO, 8'h00, 32'd0,
                                16'd0, 16'd0, 32'd0, 16'd0, 16'd0));

        // Audio routing and sectors of no known type.
        send_sector(make_sector(OP_DEMUX, 8'd0, TYPE_AUDIO, 8'h00, 32'd0,
                                16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd5, TYPE_AUDIO, 8'h00, 32'd0,
                                16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd0, TYPE_MASK, 8'h00, VIDEO_MAGIC,
                                16'd0, 16'd1, 32'd100, 16'd0, 16'd0));

        // A three-chunk frame, a chunk past the frame, zero chunk counts,
        // a frame that shrinks mid-way and the largest chunk index.
        send_sector(make_sector(OP_DEMUX, 8'd0, TYPE_DATA, 8'h00, 32'd0,
                                16'd0, 16'd3, 32'd5000, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd0, TYPE_VIDEO, 8'h00, 32'd0,
                                16'd1, 16'd3, 32'd5000, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd0, TYPE_VIDEO, 8'h00, 32'd0,
                                16'd2, 16'd3, 32'd5000, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd0, TYPE_VIDEO, 8'h00, 32'd0,
                                16'd5, 16'd0, 32'd100, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd0, TYPE_VIDEO, 8'h00, 32'd0,
                                16'hFFFF, 16'd0, 32'hFFFF_FFFF, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd0, TYPE_VIDEO, 8'h00, 32'd0,
                                16'd0, 16'd2, 32'd10000, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd0, TYPE_VIDEO, 8'h00, 32'd0,
                                16'd1, 16'd2, 32'd10, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd31, TYPE_VIDEO, 8'h00, 32'd0,
                                16'd0, 16'd1, 32'd0, 16'd0, 16'd0));
        send_sector(make_sector(OP_DEMUX, 8'd31, TYPE_DATA, 8'h00, 32'd0,
                                16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 16'd0));

        // Random part: mostly frame sequences, with scans, audio and noise.
        well_formed = 0;
        while (well_formed < RANDOM_SECTORS) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                chan = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
                case ($urandom_range(0, 3))
                    0: kind = TYPE_DATA;
                    1: kind = TYPE_VIDEO;
                    2: kind = TYPE_AUDIO;
                    default: kind = 8'($urandom) & TYPE_MASK;
                endcase
                send_sector(make_sector(OP_SCAN, chan, with_kind(kind), 8'($urandom),
                                        ($urandom_range(0, 4) == 0) ? $urandom : VIDEO_MAGIC,
                                        16'($urandom), 16'($urandom), $urandom,
                                        16'($urandom), 16'($urandom)));
                well_formed++;
            end else if (pick < 65) begin
                chan = 8'($urandom_range(0, 31));
                if ($urandom_range(0, 3) == 0) begin
                    send_sector(make_sector(OP_SCAN, chan, with_kind(TYPE_VIDEO),
                                            8'($urandom), VIDEO_MAGIC, 16'($urandom),
                                            16'($urandom), $urandom, 16'($urandom),
                                            16'($urandom)));
                    well_formed++;
                end
                cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40))
                                                  : 16'($urandom_range(1, 6));
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    fbytes = $urandom;
                end else if (cnt == 16'd0) begin
                    fbytes = $urandom_range(0, 20000);
                end else if (pick == 1) begin
                    fbytes = 32'(cnt) * 32'(CHUNK_BYTES) + $urandom_range(0, 4000);
                end else begin
                    fbytes = 32'(cnt) * 32'(CHUNK_BYTES) - $urandom_range(0, 2015);
                end
                last = (cnt == 16'd0) ? $urandom_range(0, 3) : int'(cnt) - 1;
                for (int idx = 0; idx <= last; idx++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_sector(noise_sector());
                    end
                    // Now and then a chunk goes missing.
                    if ($urandom_range(0, 19) != 0) begin
                        kind = $urandom_range(0, 1) ? TYPE_DATA : TYPE_VIDEO;
                        send_sector(make_sector(OP_DEMUX, chan, with_kind(kind),
                                                8'($urandom), $urandom, 16'(idx), cnt,
                                                fbytes, 16'($urandom), 16'($urandom)));
                        well_formed++;
                    end
                end
            end else if (pick < 80) begin
                send_sector(make_sector(OP_DEMUX, 8'($urandom_range(0, 31)),
                                        with_kind(TYPE_AUDIO), 8'($urandom), $urandom,
                                        16'($urandom), 16'($urandom), $urandom,
                                        16'($urandom), 16'($urandom)));
                well_formed++;
            end else begin
                send_sector(noise_sector());
            end
        end
        sec_if.valid <= 1'b0;

        // Let the checker count the last header word, then drain and settle.
        @(posedge i_clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (6) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (3) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
